>>> hdl/prp_pkg.sv
// Shared types and constants for the page replacement policy block.
// Used by prp_cell and page_replacement_policy; depends on nothing.
package prp_pkg;

  localparam int unsigned PAGE_W  = 16;  // page_number / evicted_page port width
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SLOTS_W = 5;
  localparam int unsigned CFG_W   = 5;   // widest register
  localparam int unsigned FCNT_W  = 32;

  localparam logic [MODE_W-1:0] POL_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] POL_LRU  = 2'd1;
  localparam logic [MODE_W-1:0] POL_SC   = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SLOTS  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SET_REF,
    OP_APPEND,
    OP_LRU_MOVE,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     inj_ref;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT
  } state_e;

endpackage

>>> hdl/prp_cell.sv
// One slot of the resident-page list: page, reference bit and the shift logic.
// Takes data from its right neighbor; depends on prp_pkg.
module prp_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned CNT_W     = 5,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  prp_pkg::cell_ctl_t    ctl_i,
  input  logic [PAGE_BITS-1:0]  key_i,
  input  logic [PAGE_BITS-1:0]  inj_page_i,
  input  logic [CNT_W-1:0]      occ_i,
  input  logic [CNT_W-1:0]      tail_i,
  input  logic [PAGE_BITS-1:0]  right_page_i,
  input  logic                  right_ref_i,
  input  logic                  after_i,
  output logic [PAGE_BITS-1:0]  page_o,
  output logic                  ref_o,
  output logic                  match_o,
  output logic                  after_o,
  output logic                  hit_ref_o
);
  import prp_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 ref_q, ref_d;
  logic                 is_tail, before_tail, match;

  assign is_tail     = (MyIdx == tail_i);
  assign before_tail = (MyIdx < tail_i);
  assign match       = (MyIdx < occ_i) && (page_q == key_i);

  always_comb begin
    page_d = page_q;
    ref_d  = ref_q;
    unique case (ctl_i.op)
      OP_HOLD: ;
      OP_SET_REF: begin
        if (match) ref_d = 1'b1;
      end
      OP_APPEND: begin
        if (is_tail) begin
          page_d = inj_page_i;
          ref_d  = ctl_i.inj_ref;
        end
      end
      OP_LRU_MOVE: begin
        // close the gap left by the hit entry, hit page goes to the tail
        if (is_tail) begin
          page_d = inj_page_i;
          ref_d  = ctl_i.inj_ref;
        end else if (before_tail && (after_i || match)) begin
          page_d = right_page_i;
          ref_d  = right_ref_i;
        end
      end
      OP_SHIFT: begin
        if (is_tail) begin
          page_d = inj_page_i;
          ref_d  = ctl_i.inj_ref;
        end else if (before_tail) begin
          page_d = right_page_i;
          ref_d  = right_ref_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 1'b0;
    end else begin
      ref_q <= ref_d;
    end
  end

  assign page_o    = page_q;
  assign ref_o     = ref_q;
  assign match_o   = match;
  assign after_o   = after_i | match;
  assign hit_ref_o = match & ref_q;

endmodule

>>> hdl/page_replacement_policy.sv
// Page replacement policy (FIFO, LRU, second chance) over a row of prp_cell slots.
// A hit, or a fault with room, finishes in the lookup state; a full-list fault goes
// to the evict state, where second chance first rotates each flagged head page to the
// tail (at most the occupancy). The next beat is taken the cycle after the result is
// made. The sequencer and the head cell's reference bit set the rotation time.
// Reset clears occupancy, reference bits and the fault count; slot pages need no clear.
module page_replacement_policy #(
  parameter int unsigned MAX_SLOTS = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [prp_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [prp_pkg::PAGE_W-1:0]  page_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        fault_o,
  output logic                        evict_valid_o,
  output logic [prp_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [prp_pkg::FCNT_W-1:0]  fault_total_o
);
  import prp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  function automatic logic [CNT_W-1:0] eff_cap(input logic [SLOTS_W-1:0] s);
    if (s == '0) return CNT_W'(1);
    else if (32'(s) > 32'(MAX_SLOTS)) return CNT_W'(MAX_SLOTS);
    else return CNT_W'(s);
  endfunction

  state_e               state_q, state_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [SLOTS_W-1:0]   slots_q, slots_d;
  logic [CNT_W-1:0]     occ_q, occ_d, cap, tail;
  logic [FCNT_W-1:0]    fcnt_q, fcnt_d;
  logic [PAGE_BITS-1:0] page_q, inj_page, head_page;
  logic                 head_ref, hit, hit_ref, full, can_finish, finish;
  logic                 res_fault, res_evict;
  logic                 out_valid_q, fault_q, evict_q;
  logic [PAGE_W-1:0]    evpage_q, res_evpage;
  cell_ctl_t            ctl;

  logic [PAGE_BITS-1:0] cell_page [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] cell_ref, match_vec, hit_ref_vec;
  logic [MAX_SLOTS:0]   after_w;

  assign cap        = eff_cap(slots_q);
  assign full       = (occ_q >= cap);
  assign hit        = |match_vec;
  assign hit_ref    = |hit_ref_vec;
  assign head_page  = cell_page[0];
  assign head_ref   = cell_ref[0];
  assign can_finish = !out_valid_q || out_ready_i;
  assign tail       = (ctl.op == OP_APPEND) ? occ_q : occ_q - CNT_W'(1);
  assign after_w[0] = 1'b0;

  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    logic [PAGE_BITS-1:0] right_page;
    logic                 right_ref;
    if (g == MAX_SLOTS - 1) begin : g_last
      assign right_page = '0;
      assign right_ref  = 1'b0;
    end else begin : g_mid
      assign right_page = cell_page[g+1];
      assign right_ref  = cell_ref[g+1];
    end
    prp_cell #(
      .IDX       (g),
      .CNT_W     (CNT_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (page_q),
      .inj_page_i   (inj_page),
      .occ_i        (occ_q),
      .tail_i       (tail),
      .right_page_i (right_page),
      .right_ref_i  (right_ref),
      .after_i      (after_w[g]),
      .page_o       (cell_page[g]),
      .ref_o        (cell_ref[g]),
      .match_o      (match_vec[g]),
      .after_o      (after_w[g+1]),
      .hit_ref_o    (hit_ref_vec[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    ctl.op      = OP_HOLD;
    ctl.inj_ref = 1'b0;
    inj_page    = page_q;
    finish      = 1'b0;
    res_fault   = 1'b0;
    res_evict   = 1'b0;
    res_evpage  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (hit) begin
          if (can_finish) begin
            finish  = 1'b1;
            state_d = ST_IDLE;
            if (mode_q == POL_LRU) begin
              ctl.op      = OP_LRU_MOVE;
              ctl.inj_ref = hit_ref;
            end else if (mode_q == POL_SC) begin
              ctl.op = OP_SET_REF;
            end
          end
        end else if (!full) begin
          if (can_finish) begin
            ctl.op    = OP_APPEND;
            finish    = 1'b1;
            res_fault = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (mode_q == POL_SC && head_ref) begin
          // rotate a flagged head to the tail with its bit cleared
          ctl.op   = OP_SHIFT;
          inj_page = head_page;
        end else if (can_finish) begin
          ctl.op     = OP_SHIFT;
          finish     = 1'b1;
          res_fault  = 1'b1;
          res_evict  = 1'b1;
          res_evpage = PAGE_W'(head_page);
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    slots_d = slots_q;
    occ_d   = occ_q;
    fcnt_d  = fcnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY: mode_d = cfg_wdata_i[MODE_W-1:0];
        REG_SLOTS: begin
          slots_d = cfg_wdata_i[SLOTS_W-1:0];
          // drop the newest entries that no longer fit
          if (occ_q > eff_cap(cfg_wdata_i[SLOTS_W-1:0])) begin
            occ_d = eff_cap(cfg_wdata_i[SLOTS_W-1:0]);
          end
        end
        default: ;
      endcase
    end
    if (ctl.op == OP_APPEND) occ_d = occ_q + CNT_W'(1);
    if (finish && res_fault && (fcnt_q != '1)) fcnt_d = fcnt_q + FCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= POL_FIFO;
      slots_q     <= SLOTS_W'(16);
      occ_q       <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      slots_q <= slots_d;
      occ_q   <= occ_d;
      fcnt_q  <= fcnt_d;
      if (finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) page_q <= PAGE_BITS'(page_number_i);
    if (finish) begin
      fault_q  <= res_fault;
      evict_q  <= res_evict;
      evpage_q <= res_evpage;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign fault_o        = fault_q;
  assign evict_valid_o  = evict_q;
  assign evicted_page_o = evpage_q;
  assign fault_total_o  = fcnt_q;

  a_occ_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= cap)
    else $error("occupancy above capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $onehot0(match_vec))
    else $error("page resident in more than one slot");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT) |-> (occ_q == cap))
    else $error("eviction with room left");

  a_evict_is_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fault_o || !evict_valid_o))
    else $error("eviction reported on a hit");

  a_fcnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (fcnt_q >= $past(fcnt_q)))
    else $error("fault count went backward");

endmodule
